FILE: rtl/point_edge_distance_window_assert.svh
// Assertion macros for the point-to-edge distance pipeline.
`ifndef POINT_EDGE_DISTANCE_WINDOW_ASSERT_SVH
`define POINT_EDGE_DISTANCE_WINDOW_ASSERT_SVH

// Implication checked on every edge outside reset.
`define PEDW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PEDW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/pedw_pkg.sv
package pedw_pkg;

   localparam int CoordW = 16;
   localparam int WinW   = 16;
   localparam int DistW  = 36;
   localparam int CsrAW  = 1;

   localparam logic [CsrAW-1:0] CSR_WINDOW_LOW  = 1'b0;
   localparam logic [CsrAW-1:0] CSR_WINDOW_HIGH = 1'b1;

   localparam logic [WinW-1:0] WINDOW_LOW_RESET  = 16'd9830;
   localparam logic [WinW-1:0] WINDOW_HIGH_RESET = 16'd55706;

   typedef struct packed {
      logic signed [CoordW-1:0] point_x;
      logic signed [CoordW-1:0] point_y;
      logic signed [CoordW-1:0] point_z;
      logic signed [CoordW-1:0] head_x;
      logic signed [CoordW-1:0] head_y;
      logic signed [CoordW-1:0] head_z;
      logic signed [CoordW-1:0] tail_x;
      logic signed [CoordW-1:0] tail_y;
      logic signed [CoordW-1:0] tail_z;
   } req_type;

   typedef struct packed {
      logic [DistW-1:0] dist_sq;
      logic             in_window;
      logic             edge_degenerate;
   } rsp_type;

endpackage

FILE: rtl/point_edge_distance_window.sv
// Point-to-edge squared distance with a projection window.
// Input channel req_: one beat carries a point and an edge (head, tail),
// all signed Q8.8. Result channel rsp_: dist_sq (Q20.16), in_window and
// edge_degenerate, one result beat per request beat, in order.
// A beat moves when valid is high and stall is low on that channel.
// Stages in order: differences, dot products, sums and range check, the
// restoring divider (one quotient bit per stage), window check and scaling,
// perpendicular components, squares, and sum/saturate into the output register.
// Throughput: one beat per cycle. The whole pipeline holds while the result
// beat is stalled; req_stall is then raised, and nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and returns
// window_low/window_high to 0.15 and 0.85 (unsigned Q0.16).
// csr_: write enable, index (0 low bound, 1 high bound), 16-bit data;
// write only while the pipeline is empty.
module point_edge_distance_window
   import pedw_pkg::*;
#(
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_write,
   input  logic [CsrAW-1:0] csr_index,
   input  logic [WinW-1:0]  csr_wdata
);

   localparam int CW   = CoordW;
   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW;
   localparam int SW   = PW + 2;
   localparam int RF   = RATIO_FRAC_BITS;
   localparam int MW   = DW + RF;
   localparam int QW   = DW + 1;
   localparam int SQW  = 2 * QW;
   localparam int SideW = 3 * DW + 2;
   localparam logic [DistW-1:0] DistMax = '1;

   logic [WinW-1:0] win_lo_ff, win_hi_ff;
   logic            adv;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_lo_ff <= WINDOW_LOW_RESET;
         win_hi_ff <= WINDOW_HIGH_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_LOW:  win_lo_ff <= csr_wdata;
            CSR_WINDOW_HIGH: win_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: differences
   logic signed [CW-1:0] px, py, pz, hx, hy, hz, tx, ty, tz;
   assign px = CW'(req_data.point_x);
   assign py = CW'(req_data.point_y);
   assign pz = CW'(req_data.point_z);
   assign hx = CW'(req_data.head_x);
   assign hy = CW'(req_data.head_y);
   assign hz = CW'(req_data.head_z);
   assign tx = CW'(req_data.tail_x);
   assign ty = CW'(req_data.tail_y);
   assign tz = CW'(req_data.tail_z);

   logic                 s1_vld_ff;
   logic signed [DW-1:0] s1_d_ff [3];
   logic signed [DW-1:0] s1_e_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (adv) s1_vld_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_d_ff[0] <= DW'(px) - DW'(tx);
         s1_d_ff[1] <= DW'(py) - DW'(ty);
         s1_d_ff[2] <= DW'(pz) - DW'(tz);
         s1_e_ff[0] <= DW'(hx) - DW'(tx);
         s1_e_ff[1] <= DW'(hy) - DW'(ty);
         s1_e_ff[2] <= DW'(hz) - DW'(tz);
      end
   end

   // stage 2: products
   logic                 s2_vld_ff;
   logic signed [PW-1:0] s2_de_ff [3];
   logic        [PW-1:0] s2_ee_ff [3];
   logic signed [DW-1:0] s2_d_ff [3];
   logic signed [DW-1:0] s2_e_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (adv) s2_vld_ff <= s1_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            s2_de_ff[i] <= PW'(s1_d_ff[i]) * PW'(s1_e_ff[i]);
            s2_ee_ff[i] <= PW'($unsigned(PW'(s1_e_ff[i]) * PW'(s1_e_ff[i])));
            s2_d_ff[i]  <= s1_d_ff[i];
            s2_e_ff[i]  <= s1_e_ff[i];
         end
      end
   end

   // stage 3: sums and range classification
   logic signed [SW-1:0] num_in;
   logic        [SW-1:0] den_in;
   assign num_in = SW'(s2_de_ff[0]) + SW'(s2_de_ff[1]) + SW'(s2_de_ff[2]);
   assign den_in = SW'(s2_ee_ff[0]) + SW'(s2_ee_ff[1]) + SW'(s2_ee_ff[2]);

   logic              s3_vld_ff;
   logic [SW-1:0]     s3_num_ff, s3_den_ff;
   logic              s3_degen_ff, s3_range_ok_ff;
   logic [3*DW-1:0]   s3_de_pack_ff [2];

   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (adv) s3_vld_ff <= s2_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3_degen_ff    <= den_in == '0;
         s3_range_ok_ff <= (den_in != '0) && !num_in[SW-1] && ($unsigned(num_in) < den_in);
         s3_num_ff      <= num_in[SW-1] ? '0 : $unsigned(num_in);
         s3_den_ff      <= den_in;
         s3_de_pack_ff[0] <= {s2_d_ff[0], s2_d_ff[1], s2_d_ff[2]};
         s3_de_pack_ff[1] <= {s2_e_ff[0], s2_e_ff[1], s2_e_ff[2]};
      end
   end

   // divider; d/e vectors ride alongside in a delay line
   logic          dv_vld;
   logic [RF-1:0] dv_quo;
   logic [SideW-1:0] dv_side;

   pedw_div #(.NumW(SW), .QBits(RF), .SideW(SideW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s3_vld_ff),
      .in_num   (s3_range_ok_ff ? s3_num_ff : '0),
      .in_den   (s3_range_ok_ff ? s3_den_ff : {{(SW-1){1'b0}}, 1'b1}),
      .in_side  ({s3_degen_ff, s3_range_ok_ff, s3_de_pack_ff[0]}),
      .out_valid(dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   logic [3*DW-1:0] e_line_ff [RF+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         e_line_ff[0] <= s3_de_pack_ff[1];
         for (int k = 1; k <= RF; k++) e_line_ff[k] <= e_line_ff[k-1];
      end
   end

   // stage 4: window check and scaling t*|e|
   logic signed [DW-1:0] dq_d [3], dq_e [3];
   assign dq_d[0] = dv_side[3*DW-1:2*DW];
   assign dq_d[1] = dv_side[2*DW-1:DW];
   assign dq_d[2] = dv_side[DW-1:0];
   assign dq_e[0] = e_line_ff[RF][3*DW-1:2*DW];
   assign dq_e[1] = e_line_ff[RF][2*DW-1:DW];
   assign dq_e[2] = e_line_ff[RF][DW-1:0];

   logic [RF+WinW-1:0] ts_c, lo_c, hi_c;
   assign ts_c = {dv_quo, {WinW{1'b0}}};
   assign lo_c = {win_lo_ff, {RF{1'b0}}};
   assign hi_c = {win_hi_ff, {RF{1'b0}}};

   logic                 s4_vld_ff, s4_degen_ff, s4_inwin_ff;
   logic [MW-1:0]        s4_prod_ff [3];
   logic                 s4_neg_ff [3];
   logic signed [DW-1:0] s4_d_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (adv) s4_vld_ff <= dv_vld;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4_degen_ff <= dv_side[SideW-1];
         s4_inwin_ff <= dv_side[SideW-2] && !(ts_c < lo_c) && !(ts_c > hi_c);
         for (int i = 0; i < 3; i++) begin
            s4_neg_ff[i]  <= dq_e[i][DW-1];
            s4_prod_ff[i] <= MW'(dq_e[i][DW-1] ? DW'(-dq_e[i]) : DW'(dq_e[i])) * MW'(dv_quo);
            s4_d_ff[i]    <= dq_d[i];
         end
      end
   end

   // stage 5: perpendicular components
   logic                 s5_vld_ff, s5_degen_ff, s5_inwin_ff;
   logic [QW-1:0]        s5_mag_ff [3];
   logic [MW:0]          rnd_in [3];
   logic signed [QW-1:0] q_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd_in[i] = ({1'b0, s4_prod_ff[i]} + ((MW+1)'(1) << (RF-1))) >> RF;
         q_in[i]   = s4_neg_ff[i] ? QW'(s4_d_ff[i]) + QW'(rnd_in[i])
                                  : QW'(s4_d_ff[i]) - QW'(rnd_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s5_vld_ff <= 1'b0;
      else if (adv) s5_vld_ff <= s4_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s5_degen_ff <= s4_degen_ff;
         s5_inwin_ff <= s4_inwin_ff;
         for (int i = 0; i < 3; i++)
            s5_mag_ff[i] <= q_in[i][QW-1] ? QW'(-q_in[i]) : QW'(q_in[i]);
      end
   end

   // stage 6: squares
   logic            s6_vld_ff, s6_degen_ff, s6_inwin_ff;
   logic [SQW-1:0]  s6_sq_ff [3];

   always_ff @(posedge clock) begin
      if (reset) s6_vld_ff <= 1'b0;
      else if (adv) s6_vld_ff <= s5_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s6_degen_ff <= s5_degen_ff;
         s6_inwin_ff <= s5_inwin_ff;
         for (int i = 0; i < 3; i++)
            s6_sq_ff[i] <= SQW'(s5_mag_ff[i]) * SQW'(s5_mag_ff[i]);
      end
   end

   // stage 7: sum, saturate, output register
   logic [SQW+1:0] sum_in;
   logic           sat_in;
   rsp_type        rsp_in;
   logic           rsp_vld_ff;
   rsp_type        rsp_ff;

   assign sum_in = (SQW+2)'(s6_sq_ff[0]) + (SQW+2)'(s6_sq_ff[1]) + (SQW+2)'(s6_sq_ff[2]);
   assign sat_in = sum_in > (SQW+2)'(DistMax);

   always_comb begin
      rsp_in.edge_degenerate = s6_degen_ff;
      rsp_in.in_window       = s6_inwin_ff;
      rsp_in.dist_sq         = (s6_inwin_ff && !sat_in) ? DistW'(sum_in) : DistMax;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (adv) rsp_vld_ff <= s6_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   `include "point_edge_distance_window_assert.svh"

   `PEDW_ASSERT_IMPL(a_degen_out, clock, reset, rsp_valid && rsp_data.edge_degenerate,
      !rsp_data.in_window && rsp_data.dist_sq == DistMax)
   `PEDW_ASSERT_IMPL(a_outwin_max, clock, reset, rsp_valid && !rsp_data.in_window,
      rsp_data.dist_sq == DistMax)
   `PEDW_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))
   `PEDW_ASSERT_IMPL(a_stall_link, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

FILE: rtl/pedw_div.sv
module pedw_div
   import pedw_pkg::*;
#(
   parameter int NumW  = 36,
   parameter int QBits = 16,
   parameter int SideW = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [NumW-1:0]  in_num,
   input  logic [NumW-1:0]  in_den,
   input  logic [SideW-1:0] in_side,
   output logic             out_valid,
   output logic [QBits-1:0] out_quo,
   output logic [SideW-1:0] out_side
);

   logic             vld_ff [QBits+1];
   logic [NumW:0]    rem_ff [QBits+1];
   logic [NumW-1:0]  den_ff [QBits+1];
   logic [QBits-1:0] quo_ff [QBits+1];
   logic [SideW-1:0] side_ff[QBits+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QBits; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= QBits; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= {1'b0, in_num};
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= QBits; k++) begin : g_step
      logic [NumW:0] shl_in;
      logic          ge_in;
      assign shl_in = {rem_ff[k-1][NumW-1:0], 1'b0};
      assign ge_in  = shl_in >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= ge_in ? (shl_in - {1'b0, den_ff[k-1]}) : shl_in;
            den_ff[k]  <= den_ff[k-1];
            quo_ff[k]  <= {quo_ff[k-1][QBits-2:0], ge_in};
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[QBits];
   assign out_quo   = quo_ff[QBits];
   assign out_side  = side_ff[QBits];

endmodule

FILE: dv/point_edge_distance_window_tb.sv
module point_edge_distance_window_tb;
   import pedw_pkg::*;

   localparam int      FracBits = 16;
   localparam longint  DistAll  = (64'd1 << DistW) - 1;
   localparam int      Latency  = FracBits + 8;
   localparam longint  CycleCap = 2000000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_write;
   logic [CsrAW-1:0] csr_index;
   logic [WinW-1:0]  csr_wdata;

   logic [WinW-1:0]  win_lo;
   logic [WinW-1:0]  win_hi;
   rsp_type          dist_expected[$];
   int               err_count;
   longint           cycle_count = 0;

   point_edge_distance_window u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleCap) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic longint round_scale(longint ratio, longint e);
      longint mag;
      longint p;
      mag = (e < 0) ? -e : e;
      p = (mag * ratio + (64'd1 << (FracBits - 1))) >>> FracBits;
      return (e < 0) ? -p : p;
   endfunction

   function automatic rsp_type project_distance(req_type r);
      rsp_type o;
      longint d[3];
      longint e[3];
      longint num;
      longint den;
      longint ratio;
      longint q;
      longint sum;
      bit     sat;
      num = 0;
      den = 0;
      d[0] = longint'(r.point_x) - longint'(r.tail_x);
      d[1] = longint'(r.point_y) - longint'(r.tail_y);
      d[2] = longint'(r.point_z) - longint'(r.tail_z);
      e[0] = longint'(r.head_x) - longint'(r.tail_x);
      e[1] = longint'(r.head_y) - longint'(r.tail_y);
      e[2] = longint'(r.head_z) - longint'(r.tail_z);
      for (int i = 0; i < 3; i++) begin
         num += d[i] * e[i];
         den += e[i] * e[i];
      end
      o.dist_sq = DistAll[DistW-1:0];
      o.in_window = 1'b0;
      o.edge_degenerate = 1'b0;
      if (den == 0) begin
         o.edge_degenerate = 1'b1;
         return o;
      end
      if (num < 0 || num >= den) return o;
      ratio = (num << FracBits) / den;
      if ((ratio << WinW) < (longint'(win_lo) << FracBits) ||
          (ratio << WinW) > (longint'(win_hi) << FracBits)) return o;
      sum = 0;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         q = d[i] - round_scale(ratio, e[i]);
         if (q < 0) q = -q;
         sum += q * q;
         if (sum > DistAll) sat = 1'b1;
      end
      o.dist_sq = sat ? DistAll[DistW-1:0] : sum[DistW-1:0];
      o.in_window = 1'b1;
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dist_expected.size() == 0) begin
            $error("unexpected result beat");
            err_count++;
         end else begin
            want = dist_expected.pop_front();
            if (rsp_data.dist_sq !== want.dist_sq) begin
               $error("dist_sq expected %0d actual %0d", want.dist_sq, rsp_data.dist_sq);
               err_count++;
            end
            if (rsp_data.in_window !== want.in_window) begin
               $error("in_window expected %0d actual %0d", want.in_window,
                      rsp_data.in_window);
               err_count++;
            end
            if (rsp_data.edge_degenerate !== want.edge_degenerate) begin
               $error("edge_degenerate expected %0d actual %0d",
                      want.edge_degenerate, rsp_data.edge_degenerate);
               err_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if ($urandom_range(3) == 0) rsp_stall <= ($urandom_range(9) > 4);
      else rsp_stall <= 1'b0;
   end

   task automatic send_beat(req_type r, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(2) == 0) ? $urandom_range(9) : 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      dist_expected.push_back(project_distance(r));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (dist_expected.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic write_window(logic [WinW-1:0] lo, logic [WinW-1:0] hi);
      csr_write <= 1'b1;
      csr_index <= CSR_WINDOW_LOW;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_WINDOW_HIGH;
      csr_wdata <= hi;
      @(posedge clock);
      csr_write <= 1'b0;
      win_lo = lo;
      win_hi = hi;
   endtask

   function automatic req_type on_edge_point(int span);
      req_type r;
      int      f;
      r.tail_x = $urandom_range(2 * span) - span;
      r.tail_y = $urandom_range(2 * span) - span;
      r.tail_z = $urandom_range(2 * span) - span;
      r.head_x = $urandom_range(2 * span) - span;
      r.head_y = $urandom_range(2 * span) - span;
      r.head_z = $urandom_range(2 * span) - span;
      f = $urandom_range(300) - 50;
      r.point_x = r.tail_x + ((r.head_x - r.tail_x) * f) / 200 + int'($urandom_range(40)) - 20;
      r.point_y = r.tail_y + ((r.head_y - r.tail_y) * f) / 200 + int'($urandom_range(40)) - 20;
      r.point_z = r.tail_z + ((r.head_z - r.tail_z) * f) / 200 + int'($urandom_range(40)) - 20;
      return r;
   endfunction

   function automatic req_type any_point();
      req_type      r;
      logic [159:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      return r;
   endfunction

   task automatic test_extremes();
      req_type r;
      r = '0;
      send_beat(r);
      r = '1;
      send_beat(r);
      r = {9{16'sh7fff}};
      send_beat(r);
      r = '0;
      r.head_x = 16'sh7fff;
      r.tail_x = 16'sh8000;
      r.point_x = 16'sh0000;
      r.point_y = 16'sh7fff;
      r.point_z = 16'sh8000;
      send_beat(r);
      r.point_x = 16'sh8000;
      send_beat(r);
      r.point_x = 16'sh7fff;
      send_beat(r);
      r = '0;
      r.head_x = 16'sh0100;
      r.point_x = 16'sh0080;
      r.point_y = 16'sh7fff;
      r.point_z = 16'sh7fff;
      send_beat(r);
      r.point_y = 16'sh8000;
      r.point_z = 16'sh8000;
      send_beat(r);
      r = '0;
      r.head_x = 16'sh7fff;
      r.head_y = 16'sh7fff;
      r.tail_x = 16'sh8000;
      r.tail_y = 16'sh8000;
      r.point_x = 16'sh7fff;
      r.point_y = 16'sh8000;
      r.point_z = 16'sh8000;
      send_beat(r);
   endtask

   task automatic test_special_cases();
      req_type r;
      r = '0;
      r.head_x = 16'sh0123;
      r.tail_x = 16'sh0123;
      r.point_x = 16'sh0400;
      send_beat(r);
      r = '0;
      r.head_x = 16'sh0100;
      r.point_x = -16'sh0010;
      send_beat(r);
      r.point_x = 16'sh0100;
      send_beat(r);
      r.point_x = 16'sh0200;
      send_beat(r);
      r.point_x = 16'sh0026;
      send_beat(r);
      r.point_x = 16'sh00d9;
      send_beat(r);
      r.point_x = 16'sh0080;
      r.point_y = 16'sh0300;
      send_beat(r);
   endtask

   task automatic test_window_settings();
      req_type r;
      logic [WinW-1:0] lo_set[5] = '{16'd0, 16'd0, 16'd40000, 16'd32768, 16'hffff};
      logic [WinW-1:0] hi_set[5] = '{16'hffff, 16'd0, 16'd20000, 16'd32768, 16'hffff};
      for (int k = 0; k < 5; k++) begin
         drain_pipe();
         write_window(lo_set[k], hi_set[k]);
         r = '0;
         r.head_x = 16'sh0100;
         r.point_x = 16'sh0080;
         send_beat(r);
         r.point_x = 16'sh0000;
         send_beat(r);
         r.point_x = 16'sh00ff;
         send_beat(r);
         for (int j = 0; j < 100; j++) send_beat(on_edge_point(2000));
      end
      drain_pipe();
      write_window(WINDOW_LOW_RESET, WINDOW_HIGH_RESET);
   endtask

   task automatic test_random_mix();
      for (int j = 0; j < 900; j++) begin
         if (j == 450) drain_pipe();
         if ($urandom_range(9) < 7)
            send_beat(on_edge_point(($urandom_range(3) == 0) ? 32767 : 3000));
         else
            send_beat(any_point(), $urandom_range(4) == 0);
      end
   endtask

   task automatic test_random_windows();
      logic [WinW-1:0] a;
      logic [WinW-1:0] b;
      for (int k = 0; k < 3; k++) begin
         drain_pipe();
         a = WinW'($urandom);
         b = WinW'($urandom);
         write_window((a < b) ? a : b, (a < b) ? b : a);
         for (int j = 0; j < 40; j++) send_beat(on_edge_point(8000), 1);
      end
   endtask

   initial begin
      err_count   = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_write   = 1'b0;
      csr_index   = CSR_WINDOW_LOW;
      csr_wdata   = '0;
      win_lo      = WINDOW_LOW_RESET;
      win_hi      = WINDOW_HIGH_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_special_cases();
      test_window_settings();
      test_random_mix();
      test_random_windows();
      drain_pipe();
      if (err_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pedw_pkg.sv
rtl/pedw_div.sv
rtl/point_edge_distance_window.sv
dv/point_edge_distance_window_tb.sv
